// ----- hw/rtl/kett_pkg.sv -----
// ----------------------------------------------------------------------------
// kett_pkg: shared types and constants of the keyed event throttle table
// Request and result payloads, the scan token that runs down the slot row,
// and the write command that the controller broadcasts to the slots.
// ----------------------------------------------------------------------------
package kett_pkg;

	localparam int KEY_BITS      = 16;
	localparam int TIME_BITS     = 32;
	localparam int WIN_BITS      = 16;
	localparam int SLOT_OUT_BITS = 3;

	localparam logic [WIN_BITS-1:0] WINDOW_RESET = 16'd200;

	typedef struct packed {
		logic [KEY_BITS-1:0]  key;
		logic [TIME_BITS-1:0] time_ms;
	} in_t;

	typedef struct packed {
		logic                     allowed;
		logic [SLOT_OUT_BITS-1:0] slot_used;
	} out_t;

	// token carried from slot to slot while a request is looked up
	typedef struct packed {
		logic [KEY_BITS-1:0]  key;
		logic [TIME_BITS-1:0] time_ms;
		logic                 hit;           // a valid slot with this key seen
		logic                 hit_throttle;  // that slot is still inside the window
		logic                 empty_found;
		logic                 oldest_found;
		logic [TIME_BITS-1:0] oldest_age;
	} scan_t;

	typedef struct packed {
		logic                 new_entry;     // claim the slot: set valid, load key
		logic [KEY_BITS-1:0]  key;
		logic [TIME_BITS-1:0] time_ms;
	} slot_wr_t;

endpackage

// ----- hw/rtl/kett_cell.sv -----
// ----------------------------------------------------------------------------
// kett_cell: one slot of the throttle table
// Holds valid, key and last-allowed time, folds its own slot into the passing
// scan token and registers the token towards the next slot.
// ----------------------------------------------------------------------------
module kett_cell #(
	parameter int SLOTS = 8,
	parameter int IDX   = 0
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic [kett_pkg::WIN_BITS-1:0]   window,
	input  logic                            tok_vld_in,
	input  kett_pkg::scan_t                 tok_in,
	input  logic [$clog2(SLOTS)-1:0]        hit_idx_in,
	input  logic [$clog2(SLOTS)-1:0]        empty_idx_in,
	input  logic [$clog2(SLOTS)-1:0]        old_idx_in,
	output logic                            tok_vld_out,
	output kett_pkg::scan_t                 tok_out,
	output logic [$clog2(SLOTS)-1:0]        hit_idx_out,
	output logic [$clog2(SLOTS)-1:0]        empty_idx_out,
	output logic [$clog2(SLOTS)-1:0]        old_idx_out,
	input  logic                            wr_en,
	input  kett_pkg::slot_wr_t              wr
);
	import kett_pkg::*;

	localparam int IDX_W = $clog2(SLOTS);
	localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);

	logic                 valid_q;
	logic [KEY_BITS-1:0]  key_q;
	logic [TIME_BITS-1:0] time_q;

	logic [TIME_BITS-1:0] age;
	logic                 hit_here;
	logic                 take_empty;
	logic                 take_old;
	scan_t                tok_nxt;
	logic [IDX_W-1:0]     hit_idx_nxt;
	logic [IDX_W-1:0]     empty_idx_nxt;
	logic [IDX_W-1:0]     old_idx_nxt;

	logic                 vld_q;
	scan_t                tok_q;
	logic [IDX_W-1:0]     hit_idx_q;
	logic [IDX_W-1:0]     empty_idx_q;
	logic [IDX_W-1:0]     old_idx_q;

	// age wraps modulo 2^32
	assign age        = tok_in.time_ms - time_q;
	assign hit_here   = valid_q && (key_q == tok_in.key) && !tok_in.hit;
	assign take_empty = !valid_q && !tok_in.empty_found;
	assign take_old   = valid_q && (!tok_in.oldest_found || (age > tok_in.oldest_age));

	always_comb begin
		tok_nxt       = tok_in;
		hit_idx_nxt   = hit_idx_in;
		empty_idx_nxt = empty_idx_in;
		old_idx_nxt   = old_idx_in;
		if (hit_here) begin
			tok_nxt.hit          = 1'b1;
			tok_nxt.hit_throttle = (age < TIME_BITS'(window));
			hit_idx_nxt          = MY_IDX;
		end
		if (take_empty) begin
			tok_nxt.empty_found = 1'b1;
			empty_idx_nxt       = MY_IDX;
		end
		if (take_old) begin
			tok_nxt.oldest_found = 1'b1;
			tok_nxt.oldest_age   = age;
			old_idx_nxt          = MY_IDX;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q   <= 1'b0;
			valid_q <= 1'b0;
		end else begin
			vld_q <= tok_vld_in;
			if (wr_en && wr.new_entry) begin
				valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		tok_q       <= tok_nxt;
		hit_idx_q   <= hit_idx_nxt;
		empty_idx_q <= empty_idx_nxt;
		old_idx_q   <= old_idx_nxt;
		if (wr_en) begin
			time_q <= wr.time_ms;
			if (wr.new_entry) begin
				key_q <= wr.key;
			end
		end
	end

	assign tok_vld_out   = vld_q;
	assign tok_out       = tok_q;
	assign hit_idx_out   = hit_idx_q;
	assign empty_idx_out = empty_idx_q;
	assign old_idx_out   = old_idx_q;

endmodule

// ----- hw/rtl/keyed_event_throttle_table.sv -----
// ----------------------------------------------------------------------------
// keyed_event_throttle_table: per-key rate limiter with oldest replacement
// Row of slot cells scanned by a token, a controller that commits the
// decision, and a one-deep result register.
// ----------------------------------------------------------------------------
// A request (key, time_ms) is answered with one result (allowed, slot_used).
// The first valid slot holding the key decides: if less than window_ms has
// passed since its stored time the request is throttled, otherwise it is
// allowed and the time refreshed. With no match the request is allowed and
// claims the lowest empty slot, or else the oldest one (lower index on a tie);
// ages are taken modulo 2^32. One request is handled at a time: the lookup
// token walks the row of SLOTS cells one cell per cycle, the outcome register
// at the tail captures what it found, and the commit writes it to the table
// and the result register, after which the next request can be accepted. A
// result left waiting in the result register does not hold up the next
// request, but a second result waits until the first is taken. window_ms
// resets to 200 and is written through the cfg channel, which is always
// ready; the valid marks clear at reset, with no clearing pass.
// ----------------------------------------------------------------------------
module keyed_event_throttle_table #(
	parameter int SLOTS = 8
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  kett_pkg::in_t                 in_data,
	output logic                          out_valid,
	input  logic                          out_stall,
	output kett_pkg::out_t                out_data,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [kett_pkg::WIN_BITS-1:0] cfg_data
);
	import kett_pkg::*;

	localparam int IDX_W = $clog2(SLOTS);

	logic [WIN_BITS-1:0] window_q;
	logic                busy_q;
	logic                accept;

	// token chain: position 0 is the incoming request, position SLOTS the tail
	logic             tok_vld   [SLOTS+1];
	scan_t            tok       [SLOTS+1];
	logic [IDX_W-1:0] hit_idx   [SLOTS+1];
	logic [IDX_W-1:0] empty_idx [SLOTS+1];
	logic [IDX_W-1:0] old_idx   [SLOTS+1];

	logic             done_q;
	scan_t            done_tok_q;
	logic [IDX_W-1:0] done_hit_idx_q;
	logic [IDX_W-1:0] done_empty_idx_q;
	logic [IDX_W-1:0] done_old_idx_q;

	logic             commit;
	logic             allowed;
	logic [IDX_W-1:0] pick;
	logic             do_write;
	slot_wr_t         wr;
	logic [SLOTS-1:0] wr_en;

	logic             out_valid_q;
	out_t             out_q;

	assign accept    = in_valid && !in_stall;
	assign in_stall  = busy_q;
	assign cfg_ready = 1'b1;

	// ---- configuration ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= WINDOW_RESET;
		end else if (cfg_valid && cfg_ready) begin
			window_q <= cfg_data;
		end
	end

	// ---- head of the chain: a fresh token with nothing found yet ----
	always_comb begin
		tok_vld[0]              = accept;
		tok[0].key              = in_data.key;
		tok[0].time_ms          = in_data.time_ms;
		tok[0].hit              = 1'b0;
		tok[0].hit_throttle     = 1'b0;
		tok[0].empty_found      = 1'b0;
		tok[0].oldest_found     = 1'b0;
		tok[0].oldest_age       = '0;
		hit_idx[0]              = '0;
		empty_idx[0]            = '0;
		old_idx[0]              = '0;
	end

	// ---- row of slot cells ----
	for (genvar i = 0; i < SLOTS; i++) begin : g_cell
		kett_cell #(
			.SLOTS (SLOTS),
			.IDX   (i)
		) u_cell (
			.clk           (clk),
			.arst_n        (arst_n),
			.window        (window_q),
			.tok_vld_in    (tok_vld[i]),
			.tok_in        (tok[i]),
			.hit_idx_in    (hit_idx[i]),
			.empty_idx_in  (empty_idx[i]),
			.old_idx_in    (old_idx[i]),
			.tok_vld_out   (tok_vld[i+1]),
			.tok_out       (tok[i+1]),
			.hit_idx_out   (hit_idx[i+1]),
			.empty_idx_out (empty_idx[i+1]),
			.old_idx_out   (old_idx[i+1]),
			.wr_en         (wr_en[i]),
			.wr            (wr)
		);
		assign wr_en[i] = do_write && (pick == IDX_W'(i));
	end

	// ---- outcome register at the tail ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
			busy_q <= 1'b0;
		end else begin
			if (tok_vld[SLOTS]) begin
				done_q <= 1'b1;
			end else if (commit) begin
				done_q <= 1'b0;
			end
			if (accept) begin
				busy_q <= 1'b1;
			end else if (commit) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (tok_vld[SLOTS]) begin
			done_tok_q       <= tok[SLOTS];
			done_hit_idx_q   <= hit_idx[SLOTS];
			done_empty_idx_q <= empty_idx[SLOTS];
			done_old_idx_q   <= old_idx[SLOTS];
		end
	end

	// ---- decision and table update ----
	// commit once the result register is free or being emptied
	assign commit = done_q && (!out_valid_q || !out_stall);

	always_comb begin
		if (done_tok_q.hit) begin
			allowed = !done_tok_q.hit_throttle;
			pick    = done_hit_idx_q;
		end else begin
			allowed = 1'b1;
			if (done_tok_q.empty_found) begin
				pick = done_empty_idx_q;
			end else if (done_tok_q.oldest_found) begin
				pick = done_old_idx_q;
			end else begin
				pick = '0;
			end
		end
	end

	// a throttled hit leaves the table untouched; an allowed hit only refreshes time
	assign do_write     = commit && allowed;
	assign wr.new_entry = !done_tok_q.hit;
	assign wr.key       = done_tok_q.key;
	assign wr.time_ms   = done_tok_q.time_ms;

	// ---- result register ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (commit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			out_q.allowed   <= allowed;
			out_q.slot_used <= SLOT_OUT_BITS'(pick);
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// ---- assertions ----
	logic [SLOTS:0] in_flight;
	for (genvar j = 0; j < SLOTS; j++) begin : g_flight
		assign in_flight[j] = tok_vld[j+1];
	end
	assign in_flight[SLOTS] = done_q;

	a_single_request: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(in_flight))
		else $error("more than one request in flight");

	a_commit_busy: assert property (@(posedge clk) disable iff (!arst_n)
		commit |-> busy_q)
		else $error("commit without an accepted request");

	a_one_slot_written: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(wr_en))
		else $error("more than one slot written");

	a_miss_has_target: assert property (@(posedge clk) disable iff (!arst_n)
		(commit && !done_tok_q.hit) |-> (done_tok_q.empty_found || done_tok_q.oldest_found))
		else $error("missed key with neither empty nor oldest slot");

	a_idle_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!busy_q |-> (in_flight == '0))
		else $error("lookup token alive while idle");

endmodule
